// ===== rtl/cpuop0_pkg.sv =====
// Shared types, constants and decode helpers for the opcode row 0 execute block.
package cpuop0_pkg;

   // Opcodes 0x00 to 0x0F
   typedef enum logic [3:0] {
      OP_NOP      = 4'h0,
      OP_LD_BC_NN = 4'h1,
      OP_LD_MBC_A = 4'h2,
      OP_INC_BC   = 4'h3,
      OP_INC_B    = 4'h4,
      OP_DEC_B    = 4'h5,
      OP_LD_B_N   = 4'h6,
      OP_RLCA     = 4'h7,
      OP_LD_MNN_SP = 4'h8,
      OP_ADD_HL_BC = 4'h9,
      OP_LD_A_MBC = 4'hA,
      OP_DEC_BC   = 4'hB,
      OP_INC_C    = 4'hC,
      OP_DEC_C    = 4'hD,
      OP_LD_C_N   = 4'hE,
      OP_RRCA     = 4'hF
   } op_type;

   // Memory write request codes
   localparam logic [1:0] WK_NONE = 2'd0;
   localparam logic [1:0] WK_BYTE = 2'd1;
   localparam logic [1:0] WK_WORD = 2'd2;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Register reset values
   localparam logic [7:0]  RESET_A     = 8'h01;
   localparam logic [3:0]  RESET_FLAGS = 4'hB;
   localparam logic [7:0]  RESET_B     = 8'h00;
   localparam logic [7:0]  RESET_C     = 8'h13;
   localparam logic [7:0]  RESET_H     = 8'h01;
   localparam logic [7:0]  RESET_L     = 8'h4D;
   localparam logic [15:0] RESET_SP    = 16'hFFFE;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One decoded instruction as it travels through the queue
   typedef struct packed {
      op_type      op;
      logic [15:0] imm;
      logic [7:0]  load_data;
      logic [4:0]  cycles;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [4:0] op_cycles(input op_type op);
      logic [4:0] c;
      case (op)
         OP_LD_BC_NN:  c = 5'd12;
         OP_LD_MNN_SP: c = 5'd20;
         OP_LD_MBC_A, OP_INC_BC, OP_LD_B_N, OP_ADD_HL_BC,
         OP_LD_A_MBC, OP_DEC_BC, OP_LD_C_N: c = 5'd8;
         default:      c = 5'd4;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/cpuop0_front.sv =====
// Front end: accepts request beats, decodes them and pushes them into the queue.
module cpuop0_front (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [3:0]              req_operation,
   input  logic [15:0]             req_immediate,
   input  logic [7:0]              req_load_data,
   input  cpuop0_pkg::q_status_type q_stat,
   output logic                    push,
   output cpuop0_pkg::item_type    push_item
);
   import cpuop0_pkg::*;

   op_type op;

   always_comb begin
      op                  = op_type'(req_operation);
      req_stall           = q_stat.full;
      push                = req_valid && !q_stat.full;
      push_item.op        = op;
      push_item.imm       = req_immediate;
      push_item.load_data = req_load_data;
      push_item.cycles    = op_cycles(op);
   end

endmodule

// ===== rtl/cpuop0_queue.sv =====
// Short FIFO that decouples the decode front end from the execute back end.
module cpuop0_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cpuop0_pkg::item_type     push_item,
   input  logic                     pop,
   output cpuop0_pkg::item_type     pop_item,
   output cpuop0_pkg::q_status_type q_stat
);
   import cpuop0_pkg::*;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                do_push, do_pop;

   always_comb begin
      q_stat.full  = (count_ff == FULL_CNT);
      q_stat.empty = (count_ff == '0);
      do_push      = push && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      pop_item     = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/cpuop0_back.sv =====
// Back end: register file, flag logic, stack pointer register and response register.
module cpuop0_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [15:0]              csr_write_data,
   input  cpuop0_pkg::q_status_type q_stat,
   input  cpuop0_pkg::item_type     pop_item,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_write_kind,
   output logic [15:0]              rsp_write_address,
   output logic [15:0]              rsp_write_data,
   output logic [4:0]               rsp_cycle_count,
   output logic [7:0]               rsp_out_a,
   output logic [7:0]               rsp_out_b,
   output logic [7:0]               rsp_out_c,
   output logic [7:0]               rsp_out_h,
   output logic [7:0]               rsp_out_l,
   output logic [3:0]               rsp_out_flags
);
   import cpuop0_pkg::*;

   // architectural state
   logic [7:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in, h_ff, h_in, l_ff, l_in;
   logic [3:0]  flags_ff, flags_in;
   logic [15:0] sp_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  wkind_ff, wkind_in;
   logic [15:0] waddr_ff, waddr_in, wdata_ff, wdata_in;
   logic [4:0]  cycles_ff;

   logic [15:0] bc, hl, bc_step;
   logic [16:0] hl_sum;
   logic [12:0] low_sum;
   logic [7:0]  r_src, r_inc, r_dec;
   logic        is_c_reg;

   always_comb begin
      pop = !q_stat.empty && (!rsp_valid_ff || !rsp_stall);

      bc      = {b_ff, c_ff};
      hl      = {h_ff, l_ff};
      hl_sum  = {1'b0, hl} + {1'b0, bc};
      low_sum = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
      bc_step = (pop_item.op == OP_INC_BC) ? bc + 16'd1 : bc - 16'd1;

      is_c_reg = (pop_item.op == OP_INC_C) || (pop_item.op == OP_DEC_C);
      r_src    = is_c_reg ? c_ff : b_ff;
      r_inc    = r_src + 8'd1;
      r_dec    = r_src - 8'd1;

      a_in = a_ff;  b_in = b_ff;  c_in = c_ff;
      h_in = h_ff;  l_in = l_ff;  flags_in = flags_ff;
      wkind_in = WK_NONE;
      waddr_in = '0;
      wdata_in = '0;

      case (pop_item.op)
         OP_NOP: begin
         end
         OP_LD_BC_NN: begin
            b_in = pop_item.imm[15:8];
            c_in = pop_item.imm[7:0];
         end
         OP_LD_MBC_A: begin
            wkind_in = WK_BYTE;
            waddr_in = bc;
            wdata_in = {8'h00, a_ff};
         end
         OP_INC_BC, OP_DEC_BC: begin
            b_in = bc_step[15:8];
            c_in = bc_step[7:0];
         end
         OP_INC_B, OP_INC_C: begin
            if (is_c_reg) begin
               c_in = r_inc;
            end else begin
               b_in = r_inc;
            end
            flags_in[FLAG_Z] = (r_inc == 8'h00);
            flags_in[FLAG_N] = 1'b0;
            flags_in[FLAG_H] = (r_src[3:0] == 4'hF);
         end
         OP_DEC_B, OP_DEC_C: begin
            if (is_c_reg) begin
               c_in = r_dec;
            end else begin
               b_in = r_dec;
            end
            flags_in[FLAG_Z] = (r_dec == 8'h00);
            flags_in[FLAG_N] = 1'b1;
            flags_in[FLAG_H] = (r_src[3:0] == 4'h0);
         end
         OP_LD_B_N: b_in = pop_item.imm[7:0];
         OP_LD_C_N: c_in = pop_item.imm[7:0];
         OP_RLCA: begin
            a_in     = {a_ff[6:0], a_ff[7]};
            flags_in = {3'b000, a_ff[7]};
         end
         OP_RRCA: begin
            a_in     = {a_ff[0], a_ff[7:1]};
            flags_in = {3'b000, a_ff[0]};
         end
         OP_LD_MNN_SP: begin
            wkind_in = WK_WORD;
            waddr_in = pop_item.imm;
            wdata_in = sp_ff;
         end
         OP_ADD_HL_BC: begin
            h_in             = hl_sum[15:8];
            l_in             = hl_sum[7:0];
            flags_in[FLAG_N] = 1'b0;
            flags_in[FLAG_H] = low_sum[12];
            flags_in[FLAG_C] = hl_sum[16];
         end
         OP_LD_A_MBC: a_in = pop_item.load_data;
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= RESET_A;
         b_ff         <= RESET_B;
         c_ff         <= RESET_C;
         h_ff         <= RESET_H;
         l_ff         <= RESET_L;
         flags_ff     <= RESET_FLAGS;
         sp_ff        <= RESET_SP;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            a_ff     <= a_in;
            b_ff     <= b_in;
            c_ff     <= c_in;
            h_ff     <= h_in;
            l_ff     <= l_in;
            flags_ff <= flags_in;
         end
         if (csr_write_enable) begin
            sp_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded only when a beat moves in
   always_ff @(posedge clock) begin
      if (pop) begin
         wkind_ff  <= wkind_in;
         waddr_ff  <= waddr_in;
         wdata_ff  <= wdata_in;
         cycles_ff <= pop_item.cycles;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_kind    = wkind_ff;
   assign rsp_write_address = waddr_ff;
   assign rsp_write_data    = wdata_ff;
   assign rsp_cycle_count   = cycles_ff;
   assign rsp_out_a         = a_ff;
   assign rsp_out_b         = b_ff;
   assign rsp_out_c         = c_ff;
   assign rsp_out_h         = h_ff;
   assign rsp_out_l         = l_ff;
   assign rsp_out_flags     = flags_ff;

endmodule

// ===== rtl/cpu_opcode_row0_execute.sv =====
// Path: an accepted request beat goes through the queue into the response register, then out.
// Throughput: one instruction per cycle unless stalled; a two-entry queue sits between decode
//   and execute, which retires one queued instruction each cycle the response register frees.
// Reset (synchronous, active high): queue and response register empty, A=01 F=B B=00 C=13
//   H=01 L=4D, stack pointer FFFE.
// Snapshot registers come straight from the register file, which updates only on a pop.
module cpu_opcode_row0_execute (
   input  logic        clock,
   input  logic        reset,
   // config port: stack pointer
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [15:0] req_immediate,
   input  logic [7:0]  req_load_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_write_kind,
   output logic [15:0] rsp_write_address,
   output logic [15:0] rsp_write_data,
   output logic [4:0]  rsp_cycle_count,
   output logic [7:0]  rsp_out_a,
   output logic [7:0]  rsp_out_b,
   output logic [7:0]  rsp_out_c,
   output logic [7:0]  rsp_out_h,
   output logic [7:0]  rsp_out_l,
   output logic [3:0]  rsp_out_flags
);
   import cpuop0_pkg::*;

   q_status_type q_stat;
   item_type     push_item;
   item_type     pop_item;
   logic         push;
   logic         pop;

   // decode: stalls only when the queue is full, never on the response side directly
   cpuop0_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_immediate (req_immediate),
      .req_load_data (req_load_data),
      .q_stat        (q_stat),
      .push          (push),
      .push_item     (push_item)
   );

   // two-deep decoupling queue
   cpuop0_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   // execute: pops when the response register is empty or being drained
   cpuop0_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .q_stat            (q_stat),
      .pop_item          (pop_item),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_kind    (rsp_write_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_cycle_count   (rsp_cycle_count),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_c         (rsp_out_c),
      .rsp_out_h         (rsp_out_h),
      .rsp_out_l         (rsp_out_l),
      .rsp_out_flags     (rsp_out_flags)
   );

`ifndef SYNTH
   // queue status is never full and empty at once
   a_q_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty");

   // a full queue must hold off the request side
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> req_stall)
      else $error("request not stalled with full queue");

   // a queued instruction with a free response slot shows up next cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!q_stat.empty && (!rsp_valid || !rsp_stall)) |=> rsp_valid)
      else $error("queued instruction not delivered");

   // pops only happen into a free response slot
   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!q_stat.empty && (!rsp_valid || !rsp_stall)))
      else $error("pop without free response slot");
`endif

endmodule

// ===== sim/cpuop0_checker.sv =====
// Checker for the opcode row 0 execute block: predicts each retired beat and compares it.
module cpuop0_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [15:0] req_immediate,
   input  logic [7:0]  req_load_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_write_kind,
   input  logic [15:0] rsp_write_address,
   input  logic [15:0] rsp_write_data,
   input  logic [4:0]  rsp_cycle_count,
   input  logic [7:0]  rsp_out_a,
   input  logic [7:0]  rsp_out_b,
   input  logic [7:0]  rsp_out_c,
   input  logic [7:0]  rsp_out_h,
   input  logic [7:0]  rsp_out_l,
   input  logic [3:0]  rsp_out_flags,
   output int          fail_count,
   output int          pending_results
);
   import cpuop0_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [15:0] data;
      logic [4:0]  cycles;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [3:0]  flags;
   } retire_snapshot_type;

   // shadow register file
   logic [7:0]  acc_q, b_q, c_q, h_q, l_q;
   logic [3:0]  flags_q;
   logic [15:0] sp_q;

   retire_snapshot_type predicted_retires[$];

   function automatic logic [7:0] inc8(input logic [7:0] v);
      logic [7:0] r;
      r = v + 8'd1;
      flags_q[FLAG_Z] = (r == 8'h00);
      flags_q[FLAG_N] = 1'b0;
      flags_q[FLAG_H] = (v[3:0] == 4'hF);
      return r;
   endfunction

   function automatic logic [7:0] dec8(input logic [7:0] v);
      logic [7:0] r;
      r = v - 8'd1;
      flags_q[FLAG_Z] = (r == 8'h00);
      flags_q[FLAG_N] = 1'b1;
      flags_q[FLAG_H] = (v[3:0] == 4'h0);
      return r;
   endfunction

   // executes one opcode on the shadow state, returns the expected snapshot
   function automatic retire_snapshot_type retire_opcode(input op_type op,
                                                          input logic [15:0] imm,
                                                          input logic [7:0] ld);
      retire_snapshot_type r;
      logic [15:0] bc, hl;
      logic [16:0] sum;
      logic [12:0] low_sum;
      r  = '0;
      bc = {b_q, c_q};
      hl = {h_q, l_q};
      r.kind = WK_NONE;
      case (op)
         OP_NOP: ;
         OP_LD_BC_NN: {b_q, c_q} = imm;
         OP_LD_MBC_A: begin
            r.kind = WK_BYTE;
            r.addr = bc;
            r.data = {8'h00, acc_q};
         end
         OP_INC_BC: {b_q, c_q} = bc + 16'd1;
         OP_DEC_BC: {b_q, c_q} = bc - 16'd1;
         OP_INC_B:  b_q = inc8(b_q);
         OP_DEC_B:  b_q = dec8(b_q);
         OP_LD_B_N: b_q = imm[7:0];
         OP_RLCA: begin
            flags_q = 4'h0;
            flags_q[FLAG_C] = acc_q[7];
            acc_q = {acc_q[6:0], acc_q[7]};
         end
         OP_LD_MNN_SP: begin
            r.kind = WK_WORD;
            r.addr = imm;
            r.data = sp_q;
         end
         OP_ADD_HL_BC: begin
            low_sum = {1'b0, hl[11:0]} + {1'b0, bc[11:0]};
            sum     = {1'b0, hl} + {1'b0, bc};
            flags_q[FLAG_N] = 1'b0;
            flags_q[FLAG_H] = low_sum[12];
            flags_q[FLAG_C] = sum[16];
            {h_q, l_q} = sum[15:0];
         end
         OP_LD_A_MBC: acc_q = ld;
         OP_INC_C:    c_q = inc8(c_q);
         OP_DEC_C:    c_q = dec8(c_q);
         OP_LD_C_N:   c_q = imm[7:0];
         OP_RRCA: begin
            flags_q = 4'h0;
            flags_q[FLAG_C] = acc_q[0];
            acc_q = {acc_q[0], acc_q[7:1]};
         end
         default: ;
      endcase
      case (op)
         OP_LD_BC_NN:  r.cycles = 5'd12;
         OP_LD_MNN_SP: r.cycles = 5'd20;
         OP_LD_MBC_A, OP_INC_BC, OP_LD_B_N, OP_ADD_HL_BC,
         OP_LD_A_MBC, OP_DEC_BC, OP_LD_C_N: r.cycles = 5'd8;
         default:      r.cycles = 5'd4;
      endcase
      r.a     = acc_q;
      r.b     = b_q;
      r.c     = c_q;
      r.h     = h_q;
      r.l     = l_q;
      r.flags = flags_q;
      return r;
   endfunction

   function automatic string describe(input retire_snapshot_type s);
      return $sformatf("wk=%0d addr=%h data=%h cyc=%0d a=%h b=%h c=%h h=%h l=%h f=%b",
                       s.kind, s.addr, s.data, s.cycles, s.a, s.b, s.c, s.h, s.l, s.flags);
   endfunction

   always @(posedge clock) begin : watch
      retire_snapshot_type got;
      retire_snapshot_type want;
      if (reset) begin
         acc_q      = RESET_A;
         flags_q    = RESET_FLAGS;
         b_q        = RESET_B;
         c_q        = RESET_C;
         h_q        = RESET_H;
         l_q        = RESET_L;
         sp_q       = RESET_SP;
         fail_count = 0;
         predicted_retires.delete();
      end else begin
         if (csr_write_enable)
            sp_q = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            got.kind   = rsp_write_kind;
            got.addr   = rsp_write_address;
            got.data   = rsp_write_data;
            got.cycles = rsp_cycle_count;
            got.a      = rsp_out_a;
            got.b      = rsp_out_b;
            got.c      = rsp_out_c;
            got.h      = rsp_out_h;
            got.l      = rsp_out_l;
            got.flags  = rsp_out_flags;
            if (predicted_retires.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response beat: %s", describe(got));
            end else begin
               want = predicted_retires.pop_front();
               if (got.kind !== want.kind || got.addr !== want.addr ||
                   got.data !== want.data || got.cycles !== want.cycles ||
                   got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                   got.h !== want.h || got.l !== want.l || got.flags !== want.flags) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("response mismatch at %0t", $realtime);
                     $display("  expected %s", describe(want));
                     $display("  actual   %s", describe(got));
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            predicted_retires.push_back(retire_opcode(op_type'(req_operation),
                                                      req_immediate, req_load_data));
      end
      pending_results = predicted_retires.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Top of the opcode row 0 testbench: clock, reset, stimulus, idling and verdict.
module tb_top;
   import cpuop0_pkg::*;

   // run limit in time units; the clock period is 4
   localparam int LIMIT_TIME = 1_600_000;
   // extra wait after the final drain, to cover the queue and the response register
   localparam int DRAIN_CYCLES = 8;
   // length of the long response hold-off
   localparam int HOLD_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_operation;
   logic [15:0] req_immediate;
   logic [7:0]  req_load_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_write_kind;
   logic [15:0] rsp_write_address;
   logic [15:0] rsp_write_data;
   logic [4:0]  rsp_cycle_count;
   logic [7:0]  rsp_out_a;
   logic [7:0]  rsp_out_b;
   logic [7:0]  rsp_out_c;
   logic [7:0]  rsp_out_h;
   logic [7:0]  rsp_out_l;
   logic [3:0]  rsp_out_flags;

   int fail_count;
   int pending_results;

   // idling controls, shared between stimulus and the response side
   bit src_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;
   int hold_requests = 0;   // bumped by the stimulus, each one starts a long hold-off

   cpu_opcode_row0_execute dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_immediate     (req_immediate),
      .req_load_data     (req_load_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_kind    (rsp_write_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_cycle_count   (rsp_cycle_count),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_c         (rsp_out_c),
      .rsp_out_h         (rsp_out_h),
      .rsp_out_l         (rsp_out_l),
      .rsp_out_flags     (rsp_out_flags)
   );

   cpuop0_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_immediate     (req_immediate),
      .req_load_data     (req_load_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_kind    (rsp_write_kind),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data),
      .rsp_cycle_count   (rsp_cycle_count),
      .rsp_out_a         (rsp_out_a),
      .rsp_out_b         (rsp_out_b),
      .rsp_out_c         (rsp_out_c),
      .rsp_out_h         (rsp_out_h),
      .rsp_out_l         (rsp_out_l),
      .rsp_out_flags     (rsp_out_flags),
      .fail_count        (fail_count),
      .pending_results   (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #(LIMIT_TIME);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: random stall bursts while idling is on,
   // and a long hold-off whenever the stimulus bumps hold_requests.
   // One nonblocking write of rsp_stall per edge.
   initial begin : rsp_side
      int stall_left;
      int hold_left;
      int holds_served;
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Byte values that hit the nibble and wrap corners of INC/DEC/ADD and the rotates
   function automatic logic [7:0] corner_byte();
      logic [7:0] v;
      case ($urandom_range(0, 6))
         0:       v = 8'h00;
         1:       v = 8'h01;
         2:       v = 8'h0F;
         3:       v = 8'h10;
         4:       v = 8'h80;
         5:       v = 8'hF0;
         default: v = 8'hFF;
      endcase
      return v;
   endfunction

   // Offer one request beat and hold it until it is taken.
   // Called at a rising edge; valid is lowered only when an idle gap is inserted,
   // so it never sees two writes in one step.
   task automatic send_beat(input op_type op, input logic [15:0] imm, input logic [7:0] ld);
      int gap;
      if (src_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_immediate <= imm;
      req_load_data <= ld;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted beat has come back. The count is
   // looked at on the falling edge, after the checker has settled for the cycle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   // Stack pointer write, only ever issued after drain()
   task automatic write_stack_pointer(input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random beats: every opcode, with a third of the operands drawn from corner bytes
   // so the register loads feed the flag edge cases of the INC/DEC/ADD that follow.
   task automatic run_random(input int count);
      op_type      op;
      logic [15:0] imm;
      logic [7:0]  ld;
      for (int i = 0; i < count; i++) begin
         op  = op_type'($urandom_range(0, 15));
         imm = 16'($urandom());
         ld  = 8'($urandom());
         if ($urandom_range(0, 2) == 0)
            imm = {corner_byte(), corner_byte()};
         if ($urandom_range(0, 2) == 0)
            ld = corner_byte();
         send_beat(op, imm, ld);
      end
   endtask

   // Directed opening, starting from the reset register values
   task automatic run_directed();
      send_beat(OP_NOP, 16'hFFFF, 8'hFF);          // operands ignored
      send_beat(OP_LD_MBC_A, 16'hA5A5, 8'h5A);     // byte write of A at BC
      send_beat(OP_LD_MNN_SP, 16'hFFFF, 8'h00);    // word write of reset SP
      send_beat(OP_LD_BC_NN, 16'hFFFF, 8'h00);
      send_beat(OP_INC_BC, 16'h1234, 8'h00);       // pair wraps up to 0000
      send_beat(OP_DEC_BC, 16'h0000, 8'h00);       // pair wraps down to FFFF
      send_beat(OP_ADD_HL_BC, 16'h0000, 8'h00);    // carry out of bits 11 and 15
      send_beat(OP_LD_B_N, 16'hAB0F, 8'h00);       // only the low byte lands
      send_beat(OP_INC_B, 16'h0000, 8'h00);        // half carry
      send_beat(OP_LD_B_N, 16'h00FF, 8'h00);
      send_beat(OP_INC_B, 16'h0000, 8'h00);        // wraps to zero
      send_beat(OP_DEC_B, 16'h0000, 8'h00);        // borrow through to FF
      send_beat(OP_LD_B_N, 16'hFF01, 8'h00);
      send_beat(OP_DEC_B, 16'h0000, 8'h00);        // lands on zero
      send_beat(OP_LD_B_N, 16'h0010, 8'h00);
      send_beat(OP_DEC_B, 16'h0000, 8'h00);        // half borrow
      send_beat(OP_LD_C_N, 16'hFFFF, 8'h00);
      send_beat(OP_INC_C, 16'h0000, 8'h00);
      send_beat(OP_DEC_C, 16'h0000, 8'h00);
      send_beat(OP_LD_A_MBC, 16'h0000, 8'h80);
      send_beat(OP_RLCA, 16'h0000, 8'h00);         // bit 7 out to carry
      send_beat(OP_RRCA, 16'h0000, 8'h00);         // bit 0 out to carry
      send_beat(OP_RRCA, 16'h0000, 8'h00);         // carry clears
      send_beat(OP_LD_A_MBC, 16'h0000, 8'h00);
      send_beat(OP_RLCA, 16'h0000, 8'h00);         // zero result, Z still cleared
      send_beat(OP_LD_BC_NN, 16'h0000, 8'h00);
      send_beat(OP_ADD_HL_BC, 16'h0000, 8'h00);    // no carries, Z kept
   endtask

   // Main sequence
   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'h0000;
      req_valid        <= 1'b0;
      req_operation    <= OP_NOP;
      req_immediate    <= 16'h0000;
      req_load_data    <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      src_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      run_directed();

      // stack pointer extremes, each read back through LD (a16),SP
      drain();
      write_stack_pointer(16'h0000);
      send_beat(OP_LD_MNN_SP, 16'h0000, 8'h00);
      drain();
      write_stack_pointer(16'hFFFF);
      send_beat(OP_LD_MNN_SP, 16'($urandom()), 8'h00);

      // long response hold-off while requests keep coming: the queue fills
      // and the request side has to stall
      drain();
      write_stack_pointer(16'($urandom()));
      hold_requests++;
      run_random(250);

      drain();
      write_stack_pointer(16'h0000);
      run_random(250);

      drain();
      write_stack_pointer(16'hFFFF);
      run_random(250);

      // last stretch runs back to back with no idling on either side
      drain();
      write_stack_pointer(16'($urandom()));
      src_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      run_random(250);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_results == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
